[hdl/blind_position_move_sequencer_top_macros.svh]
// assertion macros shared by the blind sequencer modules
// no dependencies; included by the files that carry assertions
`ifndef BLIND_POSITION_MOVE_SEQUENCER_TOP_MACROS_SVH
`define BLIND_POSITION_MOVE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPMS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BPMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/bpms_pkg.sv]
// shared types and constants for the blind position move sequencer
// no dependencies; imported by every module of the block
package bpms_pkg;

   // fixed point and field widths
   localparam int FRAC_BITS   = 10;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int TIME_W      = 16;
   localparam int DELAY_W     = 10;
   localparam int LEN_W       = TIME_W + 1;
   localparam int PROD_W      = FRAC_W + TIME_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QCOUNT_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = TIME_W;

   localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;
   localparam logic [FRAC_W-1:0] FRAC_HALF = FRAC_W'(1) << (FRAC_BITS - 1);

   // configuration reset values
   localparam logic [TIME_W-1:0]  CLOSE_TRAVEL_RESET = TIME_W'(30000);
   localparam logic [TIME_W-1:0]  OPEN_TRAVEL_RESET  = TIME_W'(30000);
   localparam logic [TIME_W-1:0]  ANGLE_CLOSE_RESET  = TIME_W'(1500);
   localparam logic [TIME_W-1:0]  ANGLE_OPEN_RESET   = TIME_W'(1500);
   localparam logic [DELAY_W-1:0] UP_DELAY_RESET     = DELAY_W'(70);
   localparam logic [DELAY_W-1:0] DOWN_DELAY_RESET   = DELAY_W'(140);
   localparam logic [TIME_W-1:0]  FULL_EXTRA_RESET   = TIME_W'(2000);

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_MOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_ARG = 2'd1,
      ST_BUSY    = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLOSE_TRAVEL = 3'd0,
      CSR_OPEN_TRAVEL  = 3'd1,
      CSR_ANGLE_CLOSE  = 3'd2,
      CSR_ANGLE_OPEN   = 3'd3,
      CSR_UP_DELAY     = 3'd4,
      CSR_DOWN_DELAY   = 3'd5,
      CSR_FULL_EXTRA   = 3'd6
   } csr_index_type;

   typedef struct packed {
      op_type              operation;
      logic [FRAC_W-1:0]   target_position;
      logic [FRAC_W-1:0]   target_angle;
   } req_type;

   typedef struct packed {
      logic       motor_power;
      logic       motor_down;
      logic       busy_res;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]  close_travel_ms;
      logic [TIME_W-1:0]  open_travel_ms;
      logic [TIME_W-1:0]  angle_close_ms;
      logic [TIME_W-1:0]  angle_open_ms;
      logic [DELAY_W-1:0] up_stop_delay_ms;
      logic [DELAY_W-1:0] down_stop_delay_ms;
      logic [TIME_W-1:0]  full_extra_ms;
   } cfg_type;

   // one motor segment: direction and length in ms
   typedef struct packed {
      logic             down;
      logic [LEN_W-1:0] len;
   } seg_type;

   // planner result: first segment to run plus the ones waiting behind it
   typedef struct packed {
      logic                          start_valid;
      seg_type                       start;
      seg_type [QUEUE_DEPTH-1:0]     queue;
      logic [QCOUNT_W-1:0]           queue_count;
   } plan_type;

endpackage

[hdl/bpms_csr.sv]
// configuration register file of the blind sequencer
// depends on bpms_pkg
module bpms_csr
   import bpms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  csr_index_type          csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CLOSE_TRAVEL: cfg_in.close_travel_ms    = csr_wdata;
            CSR_OPEN_TRAVEL:  cfg_in.open_travel_ms     = csr_wdata;
            CSR_ANGLE_CLOSE:  cfg_in.angle_close_ms     = csr_wdata;
            CSR_ANGLE_OPEN:   cfg_in.angle_open_ms      = csr_wdata;
            CSR_UP_DELAY:     cfg_in.up_stop_delay_ms   = csr_wdata[DELAY_W-1:0];
            CSR_DOWN_DELAY:   cfg_in.down_stop_delay_ms = csr_wdata[DELAY_W-1:0];
            CSR_FULL_EXTRA:   cfg_in.full_extra_ms      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.close_travel_ms    <= CLOSE_TRAVEL_RESET;
         cfg_ff.open_travel_ms     <= OPEN_TRAVEL_RESET;
         cfg_ff.angle_close_ms     <= ANGLE_CLOSE_RESET;
         cfg_ff.angle_open_ms      <= ANGLE_OPEN_RESET;
         cfg_ff.up_stop_delay_ms   <= UP_DELAY_RESET;
         cfg_ff.down_stop_delay_ms <= DOWN_DELAY_RESET;
         cfg_ff.full_extra_ms      <= FULL_EXTRA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/bpms_plan.sv]
// segment planner: lengths of the full, position and angle moves
// depends on bpms_pkg; zero-length segments are dropped here
module bpms_plan
   import bpms_pkg::*;
(
   input  req_type  item,
   input  cfg_type  cfg,
   output plan_type plan
);

   // floor(frac * t / ONE)
   function automatic logic [LEN_W-1:0] scale_frac(input logic [FRAC_W-1:0] frac,
                                                   input logic [TIME_W-1:0] t);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(frac) * PROD_W'(t);
      return prod[FRAC_BITS+LEN_W-1:FRAC_BITS];
   endfunction

   // subtract the stop delay, floored at zero
   function automatic logic [LEN_W-1:0] floor_sub(input logic [LEN_W-1:0] raw,
                                                  input logic [DELAY_W-1:0] delay);
      logic [LEN_W-1:0] d;
      d = LEN_W'(delay);
      return (raw > d) ? (raw - d) : '0;
   endfunction

   logic [FRAC_W-1:0] pos;
   logic [FRAC_W-1:0] ang;
   logic              upper_half;
   logic              pos_at_end;
   logic              ang_down;
   logic              pos_planned;
   logic              ang_planned;
   logic [LEN_W-1:0]  full_raw;
   logic [LEN_W-1:0]  pos_raw;
   logic [LEN_W-1:0]  ang_raw;
   seg_type           seg_full;
   seg_type           seg_pos;
   seg_type           seg_ang;
   logic              v_full;
   logic              v_pos;
   logic              v_ang;

   assign pos = item.target_position;
   assign ang = item.target_angle;

   // move shape from the target position
   assign upper_half  = pos > FRAC_HALF;
   assign pos_at_end  = upper_half ? (pos == FRAC_ONE) : (pos == '0);
   assign ang_down    = upper_half ^ pos_at_end;
   assign pos_planned = !pos_at_end;
   assign ang_planned = ang_down ? (ang != '0) : (ang != FRAC_ONE);

   // raw lengths, one multiplier each for position and angle
   assign full_raw = (upper_half ? LEN_W'(cfg.close_travel_ms) : LEN_W'(cfg.open_travel_ms))
                     + LEN_W'(cfg.full_extra_ms);
   assign pos_raw  = scale_frac(upper_half ? (FRAC_ONE - pos) : pos,
                                upper_half ? cfg.open_travel_ms : cfg.close_travel_ms);
   assign ang_raw  = scale_frac(ang_down ? ang : (FRAC_ONE - ang),
                                ang_down ? cfg.angle_close_ms : cfg.angle_open_ms);

   // stop delay per direction
   always_comb begin
      seg_full.down = upper_half;
      seg_full.len  = floor_sub(full_raw, upper_half ? cfg.down_stop_delay_ms
                                                     : cfg.up_stop_delay_ms);
      seg_pos.down  = !upper_half;
      seg_pos.len   = floor_sub(pos_raw, upper_half ? cfg.up_stop_delay_ms
                                                    : cfg.down_stop_delay_ms);
      seg_ang.down  = ang_down;
      seg_ang.len   = floor_sub(ang_raw, ang_down ? cfg.down_stop_delay_ms
                                                  : cfg.up_stop_delay_ms);
   end

   assign v_full = seg_full.len != '0;
   assign v_pos  = pos_planned && (seg_pos.len != '0);
   assign v_ang  = ang_planned && (seg_ang.len != '0);

   // pack the nonzero segments: first one starts, the rest queue up in order
   always_comb begin
      plan.start_valid = v_full || v_pos || v_ang;
      plan.start       = v_full ? seg_full : (v_pos ? seg_pos : seg_ang);
      plan.queue[0]    = seg_ang;
      plan.queue[1]    = seg_ang;
      plan.queue_count = '0;
      if (v_full) begin
         if (v_pos) begin
            plan.queue[0]    = seg_pos;
            plan.queue_count = v_ang ? QCOUNT_W'(2) : QCOUNT_W'(1);
         end else begin
            plan.queue_count = v_ang ? QCOUNT_W'(1) : QCOUNT_W'(0);
         end
      end else if (v_pos) begin
         plan.queue_count = v_ang ? QCOUNT_W'(1) : QCOUNT_W'(0);
      end
   end

endmodule

[hdl/bpms_seq.sv]
// segment runner: relay state, millisecond countdown and pending segments
// depends on bpms_pkg and the assertion macro header
`include "blind_position_move_sequencer_top_macros.svh"

module bpms_seq
   import bpms_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  req_type  item,
   input  plan_type plan,
   output rsp_type  result
);

   logic                      power_ff,  power_in;
   logic                      down_ff,   down_in;
   logic [LEN_W-1:0]          ticks_ff,  ticks_in;
   logic [QCOUNT_W-1:0]       qcount_ff, qcount_in;
   seg_type [QUEUE_DEPTH-1:0] queue_ff,  queue_in;
   logic [LEN_W-1:0]          ticks_dec;
   logic                      bad_arg;
   status_type                status;

   assign ticks_dec = ticks_ff - LEN_W'(1);
   assign bad_arg   = (item.target_position > FRAC_ONE) || (item.target_angle > FRAC_ONE);

   // command, tick and segment hand-over
   always_comb begin
      power_in  = power_ff;
      down_in   = down_ff;
      ticks_in  = ticks_ff;
      qcount_in = qcount_ff;
      queue_in  = queue_ff;
      status    = ST_OK;
      if (step) begin
         if (item.operation == OP_MOVE) begin
            if (bad_arg) begin
               status = ST_BAD_ARG;
            end else if (power_ff) begin
               status = ST_BUSY;
            end else begin
               power_in  = plan.start_valid;
               down_in   = plan.start_valid & plan.start.down;
               ticks_in  = plan.start_valid ? plan.start.len : '0;
               queue_in  = plan.queue;
               qcount_in = plan.queue_count;
            end
         end else if (power_ff) begin
            ticks_in = ticks_dec;
            if (ticks_dec == '0) begin
               if (qcount_ff != '0) begin
                  power_in    = 1'b1;
                  down_in     = queue_ff[0].down;
                  ticks_in    = queue_ff[0].len;
                  queue_in[0] = queue_ff[1];
                  qcount_in   = qcount_ff - QCOUNT_W'(1);
               end else begin
                  power_in = 1'b0;
                  down_in  = 1'b0;
               end
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff  <= 1'b0;
         down_ff   <= 1'b0;
         ticks_ff  <= '0;
         qcount_ff <= '0;
      end else begin
         power_ff  <= power_in;
         down_ff   <= down_in;
         ticks_ff  <= ticks_in;
         qcount_ff <= qcount_in;
      end
   end

   // pending segment payload
   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   // result reflects the state after this transfer
   always_comb begin
      result.motor_power = power_in;
      result.motor_down  = down_in;
      result.busy_res    = power_in;
      result.status      = status;
   end

   `BPMS_ASSERT_IMPLIES(a_idle_queue_empty, clock, reset, !power_ff, qcount_ff == '0, "segments pending while motor off")
   `BPMS_ASSERT_IMPLIES(a_running_has_ticks, clock, reset, power_ff, ticks_ff != '0, "motor on with no ticks left")
   `BPMS_ASSERT_IMPLIES(a_down_only_powered, clock, reset, down_ff, power_ff, "direction down while motor off")

endmodule

[hdl/blind_position_move_sequencer_top.sv]
// Blind position move sequencer. Takes one transfer per clock, ticks and position
// commands alike, while the result side is not stalled, and returns one result
// transfer for each: the transfer is held in the input register, then passes
// through the planner into the result register. The planner path,
// two 11x16 multipliers followed by the stop-delay subtract and segment packing,
// sets the clock period. A command plans up to three segments and starts the first
// at once; each tick counts the running segment down by one millisecond.
// Depends on bpms_pkg, bpms_csr, bpms_plan, bpms_seq and the assertion macro header.
`include "blind_position_move_sequencer_top_macros.svh"

module blind_position_move_sequencer_top
   import bpms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic     in_valid_ff,  in_valid_in;
   req_type  in_item_ff,   in_item_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff,       rsp_in;
   logic     advance;
   logic     step;
   cfg_type  cfg;
   plan_type plan;
   rsp_type  result;

   // pipeline flow: the result register frees when taken or empty
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      in_item_in   = (req_valid && req_ready) ? req_data : in_item_ff;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
      rsp_in       = step ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
   end

   bpms_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   bpms_plan u_plan (
      .item (in_item_ff),
      .cfg  (cfg),
      .plan (plan)
   );

   bpms_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .plan   (plan),
      .result (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BPMS_ASSERT_NEXT(a_step_gives_result, clock, reset, step, rsp_valid_ff, "processed transfer left no result")
   `BPMS_ASSERT_IMPLIES(a_busy_is_power, clock, reset, rsp_valid_ff, rsp_ff.busy_res == rsp_ff.motor_power, "busy and power disagree")
   `BPMS_ASSERT_IMPLIES(a_reject_keeps_power, clock, reset, step && (result.status == ST_BUSY), result.motor_power, "busy reject with motor off")

endmodule
